>>> rtl/dlts_pkg.sv
// Shared types and constants of the delta list task scheduler.
`timescale 1ns / 1ps
package dlts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int SUM_W      = 16 + CNT_W;

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_ADD      = 2'd1;
  localparam logic [1:0] FUNC_DELETE   = 2'd2;
  localparam logic [1:0] FUNC_DISPATCH = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic        ready;
    logic [15:0] ident;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  idx;
    entry_t            ent;
    logic              fix_en;
    logic [15:0]       fix_delay;
    logic              fix_ready;
  } cell_cmd_t;

endpackage

>>> rtl/dlts_if.sv
// Valid/ready channel interfaces for scheduler operations and results.
`timescale 1ns / 1ps
interface dlts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  handle;
  logic [15:0] delay;
  logic [15:0] period;
  logic [15:0] task_id;
  modport source (output valid, func, handle, delay, period, task_id, input ready);
  modport sink (input valid, func, handle, delay, period, task_id, output ready);
endinterface

interface dlts_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] id_out;
  logic        fired;
  logic [7:0]  fired_handle;
  modport source (output valid, ok, id_out, fired, fired_handle, input ready);
  modport sink (input valid, ok, id_out, fired, fired_handle, output ready);
endinterface

>>> rtl/dlts_cell.sv
// One slot of the delta list; shifts with its neighbors on insert and remove.
`timescale 1ns / 1ps
module dlts_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dlts_pkg::IDX_W-1:0]     cell_idx,
  input  dlts_pkg::cell_cmd_t            cmd,
  input  dlts_pkg::entry_t               prev_ent,
  input  dlts_pkg::entry_t               next_ent,
  output dlts_pkg::entry_t               ent
);
  import dlts_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   is_p, is_p1;

  assign is_p  = (cell_idx == cmd.idx);
  assign is_p1 = (cell_idx != '0) && ((cell_idx - 1'b1) == cmd.idx);

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      CELL_LOAD: begin
        if (is_p) ent_nxt = cmd.ent;
      end
      CELL_INSERT: begin
        if (is_p) begin
          ent_nxt = cmd.ent;
        end else if (cell_idx > cmd.idx) begin
          ent_nxt = prev_ent;
          if (is_p1 && cmd.fix_en) begin
            ent_nxt.delay = cmd.fix_delay;
            ent_nxt.ready = cmd.fix_ready;
          end
        end
      end
      CELL_REMOVE: begin
        if (cell_idx >= cmd.idx) begin
          ent_nxt = next_ent;
          if (is_p && cmd.fix_en) begin
            ent_nxt.delay = cmd.fix_delay;
            ent_nxt.ready = cmd.fix_ready;
          end
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // Empty slots are kept all zero, which the merge and shift logic relies on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

>>> rtl/dlts_ctrl.sv
// Sequencer that scans the slot row and issues shift commands per operation.
`timescale 1ns / 1ps
module dlts_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  dlts_in_if.sink                     in_ch,
  dlts_out_if.source                  out_ch,
  input  dlts_pkg::entry_t            rd_ent,
  input  dlts_pkg::entry_t            head_ent,
  input  logic                        tail_valid,
  output logic [dlts_pkg::IDX_W-1:0]  rd_idx,
  output dlts_pkg::cell_cmd_t         cmd
);
  import dlts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_ADD, S_DEL, S_DEL_MERGE, S_DISP
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       handle_r, handle_nxt;
  logic [15:0]      delay_r, delay_nxt;
  logic [15:0]      period_r, period_nxt;
  logic [15:0]      tid_r, tid_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [15:0]      del_r, del_nxt;
  logic             disp_r, disp_nxt;
  logic [15:0]      next_ident_r, next_ident_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             ok_r, ok_nxt;
  logic [15:0]      id_r, id_nxt;
  logic             fired_r, fired_nxt;
  logic [7:0]       fh_r, fh_nxt;

  logic             accept;
  logic             in_rng;
  logic [SUM_W-1:0] sum_add;
  logic [SUM_W-1:0] rest;
  logic [16:0]      merged;
  logic [15:0]      merged_sat;
  logic [15:0]      new_ident;
  entry_t           tick_ent;
  entry_t           new_ent;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_idx      = idx_r[IDX_W-1:0];
  assign in_rng      = (idx_r < CNT_W'(TASK_SLOTS));
  assign sum_add     = sum_r + SUM_W'(rd_ent.delay);
  assign rest        = sum_add - SUM_W'(delay_r);
  assign merged      = {1'b0, rd_ent.delay} + {1'b0, del_r};
  assign merged_sat  = merged[16] ? 16'hFFFF : merged[15:0];
  assign new_ident   = ((next_ident_r + 16'd1) == 16'd0) ? 16'd1 : next_ident_r + 16'd1;

  always_comb begin
    tick_ent = head_ent;
    if (head_ent.delay != 16'd0) tick_ent.delay = head_ent.delay - 16'd1;
    tick_ent.ready = (tick_ent.delay == 16'd0);
    new_ent        = '0;
    new_ent.valid  = 1'b1;
    new_ent.handle = handle_r;
    new_ent.delay  = delay_r - sum_r[15:0];
    new_ent.period = period_r;
    new_ent.ready  = (new_ent.delay == 16'd0);
    new_ent.ident  = new_ident;
  end

  always_comb begin
    state_nxt      = state_r;
    handle_nxt     = handle_r;
    delay_nxt      = delay_r;
    period_nxt     = period_r;
    tid_nxt        = tid_r;
    idx_nxt        = idx_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    del_nxt        = del_r;
    disp_nxt       = disp_r;
    next_ident_nxt = next_ident_r;
    out_valid_nxt  = out_valid_r;
    ok_nxt         = ok_r;
    id_nxt         = id_r;
    fired_nxt      = fired_r;
    fh_nxt         = fh_r;
    cmd            = '0;
    cmd.op         = CELL_HOLD;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          handle_nxt = in_ch.handle;
          delay_nxt  = in_ch.delay;
          period_nxt = in_ch.period;
          tid_nxt    = in_ch.task_id;
          idx_nxt    = '0;
          sum_nxt    = '0;
          disp_nxt   = 1'b0;
          ok_nxt     = 1'b0;
          id_nxt     = '0;
          fired_nxt  = 1'b0;
          fh_nxt     = '0;
          unique case (in_ch.func)
            FUNC_TICK:   state_nxt = S_TICK;
            FUNC_ADD:    state_nxt = S_ADD;
            FUNC_DELETE: state_nxt = S_DEL;
            default:     state_nxt = S_DISP;
          endcase
        end
      end
      S_TICK: begin
        if (head_ent.valid && !head_ent.ready) begin
          cmd.op  = CELL_LOAD;
          cmd.idx = '0;
          cmd.ent = tick_ent;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ADD: begin
        if (tail_valid || !in_rng) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (rd_ent.valid && (sum_add <= SUM_W'(delay_r))) begin
          sum_nxt = sum_add;
          idx_nxt = idx_r + 1'b1;
        end else begin
          // Insert here; the entry pushed back keeps only the remainder.
          cmd.op        = CELL_INSERT;
          cmd.idx       = rd_idx;
          cmd.ent       = new_ent;
          cmd.fix_en    = rd_ent.valid;
          cmd.fix_delay = (rest > SUM_W'(16'hFFFF)) ? 16'hFFFF : rest[15:0];
          cmd.fix_ready = rd_ent.ready;
          next_ident_nxt = new_ident;
          ok_nxt         = 1'b1;
          id_nxt         = new_ident;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DEL: begin
        if ((tid_r == 16'd0) || !in_rng || !rd_ent.valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (rd_ent.ident == tid_r) begin
          rem_nxt   = rd_idx;
          del_nxt   = rd_ent.delay;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DEL_MERGE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DEL_MERGE: begin
        cmd.op        = CELL_REMOVE;
        cmd.idx       = rem_r;
        cmd.fix_en    = in_rng && rd_ent.valid;
        cmd.fix_delay = merged_sat;
        cmd.fix_ready = rd_ent.ready && (merged_sat == 16'd0);
        ok_nxt        = 1'b1;
        if (disp_r && (period_r != 16'd0)) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_ADD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DISP: begin
        if (head_ent.valid && head_ent.ready) begin
          handle_nxt = head_ent.handle;
          delay_nxt  = head_ent.period;
          period_nxt = head_ent.period;
          fired_nxt  = 1'b1;
          fh_nxt     = head_ent.handle;
          disp_nxt   = 1'b1;
          rem_nxt    = '0;
          del_nxt    = head_ent.delay;
          idx_nxt    = CNT_W'(1);
          state_nxt  = S_DEL_MERGE;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      next_ident_r <= '0;
      disp_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      next_ident_r <= next_ident_nxt;
      disp_r       <= disp_nxt;
    end
    handle_r <= handle_nxt;
    delay_r  <= delay_nxt;
    period_r <= period_nxt;
    tid_r    <= tid_nxt;
    idx_r    <= idx_nxt;
    sum_r    <= sum_nxt;
    rem_r    <= rem_nxt;
    del_r    <= del_nxt;
    ok_r     <= ok_nxt;
    id_r     <= id_nxt;
    fired_r  <= fired_nxt;
    fh_r     <= fh_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = ok_r;
  assign out_ch.id_out       = id_r;
  assign out_ch.fired        = fired_r;
  assign out_ch.fired_handle = fh_r;

endmodule

>>> rtl/delta_list_task_scheduler.sv
// Top level of the delta list task scheduler: slot row plus sequencer.
`timescale 1ns / 1ps
// Keeps up to TASK_SLOTS timed tasks in a row of slot cells ordered by due
// time, each holding its delay relative to the slot before it. One operation
// is taken per transaction and gives exactly one result transaction; a new
// operation is taken only once the previous result has been delivered. The
// sequencer reads one slot per cycle while it forms the running delay sum of
// an add or searches for the identifier of a delete. A tick counts down the
// delay of the head slot. A dispatch removes a ready head and, for a periodic
// task, adds it back with its period as the new delay.
// Insertions and removals shift the whole row together, from one command broadcast to every cell.
module delta_list_task_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  dlts_in_if.sink    in_ch,
  dlts_out_if.source out_ch
);
  import dlts_pkg::*;

  entry_t           ents [TASK_SLOTS];
  cell_cmd_t        cmd;
  logic [IDX_W-1:0] rd_idx;

  dlts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .rd_ent     (ents[rd_idx]),
    .head_ent   (ents[0]),
    .tail_valid (ents[TASK_SLOTS-1].valid),
    .rd_idx     (rd_idx),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    entry_t prev_ent, next_ent;
    if (i == 0) begin : g_first
      assign prev_ent = '0;
    end else begin : g_mid
      assign prev_ent = ents[i-1];
    end
    if (i == TASK_SLOTS - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end
    dlts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .cmd      (cmd),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .ent      (ents[i])
    );
  end

endmodule

>>> rtl/dlts_chk.sv
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
module dlts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [15:0] id_out,
  input logic        fired,
  input logic [7:0]  fired_handle
);

  // Only one operation is in flight, so the input closes right after a transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an operation is in flight");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && fired) |-> ok)
    else $error("dispatch fired without ok");

  a_no_fire_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !fired) |-> (fired_handle == 8'd0))
    else $error("handle reported without a dispatch");

  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !ok) |-> (id_out == 16'd0))
    else $error("identifier reported on a failed operation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(id_out) && $stable(ok)))
    else $error("result changed while stalled");

endmodule

bind delta_list_task_scheduler dlts_chk u_dlts_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .ok           (out_ch.ok),
  .id_out       (out_ch.id_out),
  .fired        (out_ch.fired),
  .fired_handle (out_ch.fired_handle)
);
